FILE: rtl/btlv_pkg.sv
package btlv_pkg;

   // Fixed encodings of the response format.
   localparam logic [7:0] WRAP_TAG      = 8'h7C;
   localparam logic [7:0] LONG_FLAG     = 8'h80;
   localparam logic [6:0] LEN_MASK      = 7'h7F;
   localparam int         MAX_LEN_BYTES = 4;

   // Widths of the parser state.
   localparam int POS_W = 34;
   localparam int LEN_W = 32;
   localparam int LBL_W = 3;

   // Configuration register map.
   localparam int         CSR_ADDR_W       = 3;
   localparam int         CSR_DATA_W       = 32;
   localparam logic [0:0] REG_TARGET_TAG   = 1'b0;
   localparam logic [7:0] TARGET_TAG_RESET = 8'h80;

   // Queue between the parser and the result stage.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Result kinds.
   localparam logic KIND_VALUE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [3:0] {
      PH_WRAP,
      PH_OLEN1,
      PH_OLENN,
      PH_TAG,
      PH_ILEN1,
      PH_ILENN,
      PH_VALUE,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ST_FOUND,
      ST_NOTFOUND,
      ST_TRUNC,
      ST_MALFORMED
   } status_type;

   // Everything one input byte produces: an optional value beat and an
   // optional status beat, in that order.
   typedef struct packed {
      logic             has_value;
      logic [7:0]       value_byte;
      logic             has_status;
      status_type       status;
      logic [LEN_W-1:0] value_length;
   } record_type;

endpackage

FILE: rtl/ber_tlv_object_extractor_core.sv
// Latency: a byte accepted at one edge shows its first result beat after that edge.
// Throughput: one byte per cycle while the record queue is not full; a byte
// that yields both a value beat and a status beat needs two pops to drain.
// A four-record queue decouples the parser from the result port.
// Reset is synchronous and active high: it empties the queue, rearms the parser for
// a wrapper tag and sets target_tag to 0x80.
module ber_tlv_object_extractor_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_last_byte,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_kind,
   output logic [7:0]                          rsp_value_byte,
   output logic [1:0]                          rsp_status,
   output logic [btlv_pkg::LEN_W-1:0]          rsp_value_length,
   output logic                                rsp_run_end,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [btlv_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [btlv_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [btlv_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import btlv_pkg::*;

   logic [7:0] tag_ff, tag_in;
   logic       csr_wr;
   logic       queue_full, queue_empty, queue_pop, rec_push;
   record_type rec, head;

   // Register port: one register, word addressed by paddr[2].
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign tag_in     = (csr_wr && csr_paddr[2] == REG_TARGET_TAG) ? csr_pwdata[7:0] : tag_ff;
   assign csr_prdata = (csr_paddr[2] == REG_TARGET_TAG) ?
                       {{(CSR_DATA_W-8){1'b0}}, tag_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= TARGET_TAG_RESET;
      end else begin
         tag_ff <= tag_in;
      end
   end

   // Parser front end.
   btlv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .target_tag    (tag_ff),
      .queue_full    (queue_full),
      .rec_push      (rec_push),
      .rec           (rec)
   );

   // Record queue.
   btlv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (rec),
      .pop       (queue_pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head      (head)
   );

   // Result beat sequencer.
   btlv_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .queue_empty      (queue_empty),
      .queue_pop        (queue_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_kind         (rsp_kind),
      .rsp_value_byte   (rsp_value_byte),
      .rsp_status       (rsp_status),
      .rsp_value_length (rsp_value_length),
      .rsp_run_end      (rsp_run_end)
   );

   // A status beat always closes the run of its byte.
   a_status_ends_run : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_STATUS) |-> rsp_run_end)
      else $error("status beat without run_end");

   // Value beats carry no status and no length.
   a_value_clean : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_VALUE) |->
      (rsp_status == ST_FOUND && rsp_value_length == '0))
      else $error("value beat with status fields set");

   // Only a found status carries a length.
   a_length_only_found : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_STATUS && rsp_status != ST_FOUND) |->
      (rsp_value_length == '0))
      else $error("length on a status other than found");

   // The record queue is empty right after reset.
   a_empty_after_reset : assert property (@(posedge clock)
      $fell(reset) |-> rsp_empty)
      else $error("results pending after reset");

endmodule

FILE: rtl/btlv_front.sv
module btlv_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_byte,
   input  logic [7:0]            target_tag,
   input  logic                  queue_full,
   output logic                  rec_push,
   output btlv_pkg::record_type  rec
);
   import btlv_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] limit_ff, limit_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LBL_W-1:0] lbl_ff, lbl_in;
   logic             matched_ff, matched_in;
   logic [LEN_W-1:0] vrem_ff, vrem_in;
   logic             reported_ff, reported_in;

   logic             accept;
   logic [7:0]       b;
   logic [POS_W-1:0] np;
   logic [LEN_W-1:0] len_short, len_long, len_cand;
   logic [POS_W:0]   sum_np_len, np_plus2;
   logic [POS_W-1:0] limit_new;
   logic             outer_walk_fail, inner_walk_fail, elem_over;
   logic [6:0]       nb;
   logic             len_bad;
   logic [LBL_W-1:0] lbl_dec;
   logic [LEN_W-1:0] vrem_dec;
   logic             outer_fin, elem_fin;
   logic             rep;
   status_type       rep_st;
   logic             emit_val;

   assign accept   = req_push && !queue_full;
   assign req_full = queue_full;
   assign b        = req_data_byte;

   // Shared position arithmetic: one add for the end of a length field and
   // one for the two-byte room check before a tag.
   assign np         = pos_ff + POS_W'(1);
   assign len_short  = {{(LEN_W-8){1'b0}}, b};
   assign len_long   = {len_ff[LEN_W-9:0], b};
   assign len_cand   = (phase_ff == PH_OLENN || phase_ff == PH_ILENN) ? len_long : len_short;
   assign sum_np_len = {1'b0, np} + {{(POS_W+1-LEN_W){1'b0}}, len_cand};
   assign limit_new  = sum_np_len[POS_W-1:0];
   assign np_plus2   = {1'b0, np} + (POS_W+1)'(2);

   assign outer_walk_fail = np_plus2 > {1'b0, limit_new};
   assign inner_walk_fail = np_plus2 > {1'b0, limit_ff};
   assign elem_over       = sum_np_len > {1'b0, limit_ff};

   assign nb       = b[6:0] & LEN_MASK;
   assign len_bad  = (nb == 7'd0) || (nb > 7'(MAX_LEN_BYTES));
   assign lbl_dec  = lbl_ff - LBL_W'(1);
   assign vrem_dec = vrem_ff - LEN_W'(1);

   // Next parser state and the beats caused by the current byte.
   always_comb begin
      phase_in    = phase_ff;
      pos_in      = np;
      limit_in    = limit_ff;
      len_in      = len_ff;
      lbl_in      = lbl_ff;
      matched_in  = matched_ff;
      vrem_in     = vrem_ff;
      reported_in = reported_ff;
      outer_fin   = 1'b0;
      elem_fin    = 1'b0;
      rep         = 1'b0;
      rep_st      = ST_NOTFOUND;
      emit_val    = 1'b0;

      case (phase_ff)
         PH_WRAP: begin
            if (b != WRAP_TAG) begin
               rep    = 1'b1;
               rep_st = ST_MALFORMED;
            end else begin
               phase_in = PH_OLEN1;
            end
         end
         PH_OLEN1, PH_ILEN1: begin
            len_in = '0;
            if ((b & LONG_FLAG) == 8'h00) begin
               len_in = len_short;
               lbl_in = '0;
               if (phase_ff == PH_OLEN1) outer_fin = 1'b1;
               else                      elem_fin  = 1'b1;
            end else if (len_bad) begin
               rep    = 1'b1;
               rep_st = ST_MALFORMED;
            end else begin
               lbl_in   = nb[LBL_W-1:0];
               phase_in = (phase_ff == PH_OLEN1) ? PH_OLENN : PH_ILENN;
            end
         end
         PH_OLENN, PH_ILENN: begin
            len_in = len_long;
            lbl_in = lbl_dec;
            if (lbl_dec == '0) begin
               if (phase_ff == PH_OLENN) outer_fin = 1'b1;
               else                      elem_fin  = 1'b1;
            end
         end
         PH_TAG: begin
            matched_in = (b == target_tag);
            phase_in   = PH_ILEN1;
         end
         PH_VALUE: begin
            emit_val = matched_ff;
            vrem_in  = vrem_dec;
            if (vrem_dec == '0) begin
               if (matched_ff) begin
                  rep    = 1'b1;
                  rep_st = ST_FOUND;
               end else if (inner_walk_fail) begin
                  rep    = 1'b1;
                  rep_st = ST_NOTFOUND;
               end else begin
                  phase_in = PH_TAG;
               end
            end
         end
         default: begin
         end
      endcase

      // The wrapper length is complete: fix its end and look for room for a tag.
      if (outer_fin) begin
         limit_in = limit_new;
         if (outer_walk_fail) begin
            rep    = 1'b1;
            rep_st = ST_NOTFOUND;
         end else begin
            phase_in = PH_TAG;
         end
      end

      // An element header is complete: check its value against the wrapper end.
      if (elem_fin) begin
         if (elem_over) begin
            rep    = 1'b1;
            rep_st = matched_ff ? ST_TRUNC : ST_NOTFOUND;
         end else if (len_cand == '0) begin
            if (matched_ff) begin
               rep    = 1'b1;
               rep_st = ST_FOUND;
            end else if (inner_walk_fail) begin
               rep    = 1'b1;
               rep_st = ST_NOTFOUND;
            end else begin
               phase_in = PH_TAG;
            end
         end else begin
            vrem_in  = len_cand;
            phase_in = PH_VALUE;
         end
      end

      if (rep) begin
         reported_in = 1'b1;
         phase_in    = PH_DONE;
      end

      rec.has_value    = emit_val;
      rec.value_byte   = b;
      rec.value_length = (rep && rep_st == ST_FOUND) ? len_in : '0;

      // The final byte forces the one status beat and rearms the parser.
      if (req_last_byte) begin
         if (!reported_in) begin
            rep = 1'b1;
            if (phase_in inside {PH_WRAP, PH_OLEN1, PH_OLENN}) begin
               rep_st = ST_MALFORMED;
            end else if (phase_in == PH_VALUE && matched_in) begin
               rep_st = ST_TRUNC;
            end else begin
               rep_st = ST_NOTFOUND;
            end
         end
         phase_in    = PH_WRAP;
         pos_in      = '0;
         limit_in    = '0;
         len_in      = '0;
         lbl_in      = '0;
         matched_in  = 1'b0;
         vrem_in     = '0;
         reported_in = 1'b0;
      end

      rec.has_status = rep;
      rec.status     = rep_st;
   end

   assign rec_push = accept && (emit_val || rep);

   // Parser state advances on every accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WRAP;
         pos_ff      <= '0;
         limit_ff    <= '0;
         len_ff      <= '0;
         lbl_ff      <= '0;
         matched_ff  <= 1'b0;
         vrem_ff     <= '0;
         reported_ff <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         limit_ff    <= limit_in;
         len_ff      <= len_in;
         lbl_ff      <= lbl_in;
         matched_ff  <= matched_in;
         vrem_ff     <= vrem_in;
         reported_ff <= reported_in;
      end
   end

endmodule

FILE: rtl/btlv_queue.sv
module btlv_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  btlv_pkg::record_type push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output btlv_pkg::record_type head
);
   import btlv_pkg::*;

   record_type          mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + (QUEUE_AW+1)'(1);
      if (do_pop && !do_push) count_in = count_ff - (QUEUE_AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Record storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/btlv_back.sv
module btlv_back (
   input  logic                         clock,
   input  logic                         reset,
   input  btlv_pkg::record_type         head,
   input  logic                         queue_empty,
   output logic                         queue_pop,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic                         rsp_kind,
   output logic [7:0]                   rsp_value_byte,
   output logic [1:0]                   rsp_status,
   output logic [btlv_pkg::LEN_W-1:0]   rsp_value_length,
   output logic                         rsp_run_end
);
   import btlv_pkg::*;

   logic second_ff, second_in;
   logic both, show_status, take;

   // A record with both beats shows its value beat first, then its status.
   assign both        = head.has_value && head.has_status;
   assign show_status = !head.has_value || second_ff;
   assign take        = rsp_pop && !queue_empty;
   assign queue_pop   = take && (show_status || !head.has_status);

   assign rsp_empty        = queue_empty;
   assign rsp_kind         = show_status ? KIND_STATUS : KIND_VALUE;
   assign rsp_value_byte   = show_status ? 8'h00 : head.value_byte;
   assign rsp_status       = show_status ? head.status : ST_FOUND;
   assign rsp_value_length = show_status ? head.value_length : '0;
   assign rsp_run_end      = show_status || !head.has_status;

   // Tracks whether the value beat of the head record has gone out.
   always_comb begin
      second_in = second_ff;
      if (take) begin
         if (both && !second_ff) second_in = 1'b1;
         else if (queue_pop)     second_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
      end
   end

endmodule

FILE: test/ber_tlv_object_extractor_core_tb.sv
module ber_tlv_object_extractor_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import btlv_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_BYTES   = 290;

   typedef logic [7:0] octet_q_type[$];

   typedef struct {
      logic [7:0] data;
      logic       closing;
   } stream_item_type;

   typedef struct {
      logic             kind;
      logic [7:0]       value_byte;
      status_type       status;
      logic [LEN_W-1:0] value_length;
      logic             run_end;
   } tlv_beat_type;

   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  req_push       = 1'b0;
   logic                  req_full;
   logic [7:0]            req_data_byte  = 8'h00;
   logic                  req_last_byte  = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop        = 1'b0;
   logic                  rsp_kind;
   logic [7:0]            rsp_value_byte;
   logic [1:0]            rsp_status;
   logic [LEN_W-1:0]      rsp_value_length;
   logic                  rsp_run_end;
   logic                  csr_psel       = 1'b0;
   logic                  csr_penable    = 1'b0;
   logic                  csr_pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr      = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata     = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ber_tlv_object_extractor_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_kind         (rsp_kind),
      .rsp_value_byte   (rsp_value_byte),
      .rsp_status       (rsp_status),
      .rsp_value_length (rsp_value_length),
      .rsp_run_end      (rsp_run_end),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // Parser shadow state, kept in step with every accepted byte.
   phase_type        prs_phase;
   logic [POS_W-1:0] prs_pos;
   logic [POS_W-1:0] prs_limit;
   logic [LEN_W-1:0] prs_len;
   logic [LEN_W-1:0] prs_remaining;
   logic [LBL_W-1:0] prs_len_left;
   logic             prs_matched;
   logic             prs_reported;
   logic [7:0]       prs_target;

   tlv_beat_type    expected_beats[$];
   stream_item_type pending_bytes[$];
   stream_item_type next_item;
   tlv_beat_type    oldest_beat;

   int send_idle_pct   = 0;
   int pop_stall_pct   = 0;
   int error_count     = 0;
   int bytes_accepted  = 0;
   int responses_seen  = 0;
   int beats_checked   = 0;
   int value_beats     = 0;
   int idle_cycles     = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void add_beat(logic kind, logic [7:0] vb, status_type st,
                                    logic [LEN_W-1:0] vlen);
      tlv_beat_type bt;
      bt.kind         = kind;
      bt.value_byte   = vb;
      bt.status       = st;
      bt.value_length = vlen;
      bt.run_end      = 1'b0;
      expected_beats = {expected_beats, bt};
   endfunction

   // A status closes the response; later bytes up to the final one are dropped.
   function automatic void report_status(status_type st);
      add_beat(KIND_STATUS, 8'h00, st, (st == ST_FOUND) ? prs_len : '0);
      prs_reported = 1'b1;
      prs_phase    = PH_DONE;
   endfunction

   // A tag needs at least a tag byte and a length byte before the wrapper end.
   function automatic void walk_or_stop(logic [POS_W-1:0] np);
      if (64'(np) + 64'd2 > 64'(prs_limit)) report_status(ST_NOTFOUND);
      else prs_phase = PH_TAG;
   endfunction

   function automatic void close_wrapper_length(logic [POS_W-1:0] np);
      prs_limit = np + POS_W'(prs_len);
      walk_or_stop(np);
   endfunction

   function automatic void close_element_header(logic [POS_W-1:0] np);
      if (64'(np) + 64'(prs_len) > 64'(prs_limit)) begin
         report_status(prs_matched ? ST_TRUNC : ST_NOTFOUND);
      end else if (prs_len == 0) begin
         if (prs_matched) report_status(ST_FOUND);
         else walk_or_stop(np);
      end else begin
         prs_remaining = prs_len;
         prs_phase     = PH_VALUE;
      end
   endfunction

   // First length octet: short form, or a count of big-endian length octets.
   function automatic logic start_length(logic [7:0] b, phase_type long_phase);
      logic [6:0] nb;
      nb      = b[6:0];
      prs_len = '0;
      if (b < LONG_FLAG) begin
         prs_len      = LEN_W'(b);
         prs_len_left = '0;
         return 1'b1;
      end
      if (nb == 0 || nb > MAX_LEN_BYTES) return 1'b0;
      prs_len_left = LBL_W'(nb);
      prs_phase    = long_phase;
      return 1'b1;
   endfunction

   function automatic void clear_parser();
      prs_phase     = PH_WRAP;
      prs_pos       = '0;
      prs_limit     = '0;
      prs_len       = '0;
      prs_remaining = '0;
      prs_len_left  = '0;
      prs_matched   = 1'b0;
      prs_reported  = 1'b0;
   endfunction

   // Advance the shadow parser by one accepted byte and queue its beats.
   function automatic void parse_byte(logic [7:0] b, logic closing);
      logic [POS_W-1:0] np;
      int               first;
      np    = prs_pos + 1'b1;
      first = expected_beats.size();
      case (prs_phase)
         PH_WRAP: begin
            if (b != WRAP_TAG) report_status(ST_MALFORMED);
            else prs_phase = PH_OLEN1;
         end
         PH_OLEN1: begin
            if (!start_length(b, PH_OLENN)) report_status(ST_MALFORMED);
            else if (prs_len_left == 0) close_wrapper_length(np);
         end
         PH_ILEN1: begin
            if (!start_length(b, PH_ILENN)) report_status(ST_MALFORMED);
            else if (prs_len_left == 0) close_element_header(np);
         end
         PH_OLENN, PH_ILENN: begin
            prs_len      = {prs_len[LEN_W-9:0], b};
            prs_len_left = prs_len_left - 1'b1;
            if (prs_len_left == 0) begin
               if (prs_phase == PH_OLENN) close_wrapper_length(np);
               else close_element_header(np);
            end
         end
         PH_TAG: begin
            prs_matched = (b == prs_target);
            prs_phase   = PH_ILEN1;
         end
         PH_VALUE: begin
            // Value beats carry a zero status code, which is the found code.
            if (prs_matched) add_beat(KIND_VALUE, b, ST_FOUND, '0);
            prs_remaining = prs_remaining - 1'b1;
            if (prs_remaining == 0) begin
               if (prs_matched) report_status(ST_FOUND);
               else walk_or_stop(np);
            end
         end
         default: ;
      endcase
      prs_pos = np;

      // The final byte forces a status if none was given, then rearms.
      if (closing) begin
         if (!prs_reported) begin
            if (prs_phase inside {PH_WRAP, PH_OLEN1, PH_OLENN}) report_status(ST_MALFORMED);
            else if (prs_phase == PH_VALUE && prs_matched) report_status(ST_TRUNC);
            else report_status(ST_NOTFOUND);
         end
         clear_parser();
      end
      if (expected_beats.size() > first)
         expected_beats[expected_beats.size() - 1].run_end = 1'b1;
   endfunction

   // BER length field, now and then malformed on purpose.
   function automatic void put_length(ref octet_q_type q, input logic [31:0] len);
      int unsigned nb;
      int          k;
      if ($urandom_range(39) == 0) begin
         if ($urandom_range(1) == 0) q = {q, LONG_FLAG};
         else q = {q, 8'(LONG_FLAG + $urandom_range(127, MAX_LEN_BYTES + 1))};
      end else if (len < 128 && $urandom_range(3) != 0) begin
         q = {q, len[7:0]};
      end else begin
         nb = (len > 32'hFFFFFF) ? 4 : (len > 32'hFFFF) ? 3 : (len > 32'hFF) ? 2 : 1;
         nb = $urandom_range(MAX_LEN_BYTES, nb);
         q = {q, 8'(LONG_FLAG | nb)};
         for (k = int'(nb) - 1; k >= 0; k--) q = {q, len[8*k +: 8]};
      end
   endfunction

   function automatic void queue_message(octet_q_type msg, logic closes);
      stream_item_type beat_item;
      foreach (msg[i]) begin
         beat_item.data    = msg[i];
         beat_item.closing = closes && (i == msg.size() - 1);
         pending_bytes = {pending_bytes, beat_item};
      end
   endfunction

   // One random response: mostly well-formed wrappers with random elements,
   // the rest noise, corrupted bytes or responses cut short.
   function automatic void queue_response();
      octet_q_type body;
      octet_q_type msg;
      logic [31:0] wrap_len;
      int unsigned pick;
      int unsigned vlen;
      int unsigned keep;
      pick = $urandom_range(99);
      if (pick < 8) begin
         repeat ($urandom_range(5, 1)) msg = {msg, 8'($urandom)};
      end else begin
         repeat ($urandom_range(4)) begin
            vlen = ($urandom_range(9) == 0) ? $urandom_range(140, 7) : $urandom_range(5);
            body = {body, (($urandom_range(2) == 0) ? prs_target : 8'($urandom))};
            if ($urandom_range(19) == 0) begin
               // Declared length far beyond anything that follows.
               put_length(body, $urandom);
            end else begin
               put_length(body, vlen);
               repeat (vlen) body = {body, 8'($urandom)};
            end
         end
         case ($urandom_range(9))
            0:       wrap_len = body.size() + $urandom_range(6, 1);
            1:       wrap_len = $urandom_range(body.size());
            2:       wrap_len = $urandom;
            default: wrap_len = body.size();
         endcase
         msg = {msg, WRAP_TAG};
         put_length(msg, wrap_len);
         msg = {msg, body};
         if ($urandom_range(2) == 0)
            repeat ($urandom_range(3, 1)) msg = {msg, 8'($urandom)};
         if (pick < 18) begin
            msg[$urandom_range(msg.size() - 1)] =
               ($urandom_range(1) == 0) ? LONG_FLAG : 8'($urandom);
         end else if (pick < 30) begin
            keep = $urandom_range(msg.size(), 1);
            while (msg.size() > keep) void'(msg.pop_back());
         end
      end
      queue_message(msg, 1'b1);
   endfunction

   function automatic void check_field(string name, logic [31:0] actual, logic [31:0] wanted);
      if (actual !== wanted) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, wanted, actual);
         error_count++;
      end
   endfunction

   // Register writes happen only with the block idle.
   task automatic write_target_tag(input logic [7:0] tag);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(REG_TARGET_TAG));
      csr_pwdata  <= CSR_DATA_W'(tag);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      prs_target = tag;
   endtask

   // Wait until every byte is in and every beat is out, then let the block settle.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_push || expected_beats.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [7:0] tag, input int send_idle, input int pop_stall);
      write_target_tag(tag);
      @(negedge clock);
      send_idle_pct = send_idle;
      pop_stall_pct = pop_stall;
      while (pending_bytes.size() < PHASE_BYTES) queue_response();
      wait_idle();
   endtask

   // Byte driver: loads the next pending byte when the bus is free, idling at random by send_idle_pct.
   always @(posedge clock) begin
      if (reset) begin
         req_push      <= 1'b0;
         req_data_byte <= 8'h00;
         req_last_byte <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            parse_byte(req_data_byte, req_last_byte);
            bytes_accepted++;
            if (req_last_byte) responses_seen++;
         end
         if (!req_push || !req_full) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = pending_bytes.pop_front();
               req_data_byte <= next_item.data;
               req_last_byte <= next_item.closing;
               req_push      <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Result monitor: each accepted beat is checked against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_beats.size() == 0) begin
               $error("Unexpected result beat: kind %0d, status %0d", rsp_kind, rsp_status);
               error_count++;
            end else begin
               oldest_beat = expected_beats.pop_front();
               beats_checked++;
               if (oldest_beat.kind == KIND_VALUE) value_beats++;
               check_field("kind", 32'(rsp_kind), 32'(oldest_beat.kind));
               check_field("value_byte", 32'(rsp_value_byte), 32'(oldest_beat.value_byte));
               check_field("status", 32'(rsp_status), 32'(oldest_beat.status));
               check_field("value_length", rsp_value_length, oldest_beat.value_length);
               check_field("run_end", 32'(rsp_run_end), 32'(oldest_beat.run_end));
            end
         end
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   // Watchdog: too long without any beat on any port ends the run.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      octet_q_type msg;
      clear_parser();
      prs_target = TARGET_TAG_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed responses with the reset target tag.
      msg = {8'h00};                                   // wrong wrapper tag
      queue_message(msg, 1'b1);
      msg = {WRAP_TAG, LONG_FLAG};                     // indefinite wrapper length
      queue_message(msg, 1'b1);
      msg = {WRAP_TAG, 8'h85};                         // too many length octets
      queue_message(msg, 1'b1);
      msg = {WRAP_TAG, 8'h82, 8'h01};                  // ends inside the wrapper length
      queue_message(msg, 1'b1);
      // Largest wrapper length, then an element with indefinite length.
      msg = {WRAP_TAG, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, LONG_FLAG};
      queue_message(msg, 1'b1);
      // Empty unmatched element, then a match streamed out; the sender holds
      // off until the status arrives, then sends the ignored tail.
      msg = {WRAP_TAG, 8'h08, 8'h11, 8'h00, 8'h80, 8'h02, 8'hA5, 8'h5A};
      queue_message(msg, 1'b0);
      wait_idle();
      msg = {8'h55, 8'hFF};
      queue_message(msg, 1'b1);
      wait_idle();

      // Random phases across target tags and idling patterns.
      run_phase(8'h00, 0, 0);
      run_phase(8'hFF, 68, 0);
      run_phase(8'($urandom), 0, 68);
      run_phase(8'($urandom), 22, 22);

      $display("Checked %0d result beats (%0d value bytes) from %0d bytes in %0d responses.",
               beats_checked, value_beats, bytes_accepted, responses_seen);
      $display("Target tags spanned reset, both extremes and random picks under four idling mixes.");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
